### rtl/hrms_pkg.sv
// Shared types and constants for the hybrid run merge sorter.
package hrms_pkg;

    localparam int VALUE_W      = 32;
    localparam int CAPACITY_DEF = 64;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic sample;
    } t_min_ctl;

endpackage

### rtl/hrms_in_if.sv
// Input channel: one element per beat, with end-of-set flag.
interface hrms_in_if;
    import hrms_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

### rtl/hrms_out_if.sv
// Result channel: sorted elements, end-of-set flag and overflow flag.
interface hrms_out_if;
    import hrms_pkg::*;

    logic   valid;
    logic   ready;
    t_value sorted_value;
    logic   last_res;
    logic   overflow;

    modport source (output valid, output sorted_value, output last_res, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_res, input overflow,
                    output ready);
endinterface

### rtl/hrms_ram.sv
// Generic simple dual-port RAM with registered read.
module hrms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/hrms_min_unit.sv
// Shared signed compare unit that tracks the smallest sampled element and its index.
module hrms_min_unit #(
    parameter int IDX_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrms_pkg::t_min_ctl i_ctl,
    input  hrms_pkg::t_value  i_data,
    input  logic [IDX_W-1:0]  i_idx,
    output hrms_pkg::t_value  o_best,
    output logic [IDX_W-1:0]  o_best_idx
);
    import hrms_pkg::*;

    logic             r_best_vld;
    t_value           r_best;
    logic [IDX_W-1:0] r_best_idx;
    logic             take;

    assign take = i_ctl.sample && (!r_best_vld || (i_data < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld <= 1'b0;
        end else if (i_ctl.clear) begin
            r_best_vld <= 1'b0;
        end else if (take) begin
            r_best_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && take) begin
            r_best     <= i_data;
            r_best_idx <= i_idx;
        end
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;
endmodule

### rtl/hybrid_run_merge_sorter.sv
// Top level: collects a set of signed elements and returns it in ascending order.
//
//   channel   dir  beat payload                          handshake
//   i_item    in   value[31:0], last                     valid/ready
//   o_res     out  sorted_value[31:0], last_res, overflow valid/ready
//
// Fill: one element accepted per cycle until the beat with last set.
// Sort/emit: each result comes from a minimum search over the n stored elements
// through the one RAM read port and compare unit, and is then held on o_res
// until taken.
// i_item is not ready from the last beat until the final result is taken.
// Synchronous active-low reset clears count, overflow flag and sequencer.
module hybrid_run_merge_sorter #(
    parameter int CAPACITY = hrms_pkg::CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrms_in_if.sink    i_item,
    hrms_out_if.source o_res
);
    import hrms_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_count;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_addr;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pend_idx;
    logic [CNT_W-1:0]  r_emitted;
    logic [CAPACITY-1:0] r_used;

    logic              in_acc;
    logic              out_acc;
    logic              full;
    logic              is_last;
    logic              ram_we;
    t_value            rd_data;
    t_value            best;
    logic [IDX_W-1:0]  best_idx;
    t_min_ctl          min_ctl;

    assign full    = (r_count == CNT_W'(CAPACITY));
    assign in_acc  = i_item.valid && i_item.ready;
    assign out_acc = o_res.valid && o_res.ready;
    assign is_last = ({1'b0, r_emitted} + (CNT_W+1)'(1)) == {1'b0, r_count};

    hrms_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[IDX_W-1:0]),
        .i_wdata(i_item.value),
        .i_raddr(r_addr[IDX_W-1:0]),
        .o_rdata(rd_data)
    );

    hrms_min_unit #(
        .IDX_W(IDX_W)
    ) u_min (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (min_ctl),
        .i_data    (rd_data),
        .i_idx     (r_pend_idx),
        .o_best    (best),
        .o_best_idx(best_idx)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_FILL: begin
                if (in_acc && i_item.last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if ((r_addr == r_count) && !r_pend) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_acc) begin
                    n_state = is_last ? ST_FILL : ST_SCAN;
                end
            end
            default: n_state = ST_FILL;
        endcase
    end

    always_comb begin
        i_item.ready       = (r_state == ST_FILL);
        o_res.valid        = (r_state == ST_EMIT);
        o_res.sorted_value = best;
        o_res.last_res     = is_last;
        o_res.overflow     = r_ovf;
        ram_we             = in_acc && !full;
        min_ctl.clear      = (r_state == ST_FILL) || out_acc;
        min_ctl.sample     = (r_state == ST_SCAN) && r_pend && !r_used[r_pend_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_emitted <= '0;
            r_used    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_FILL: begin
                    r_used    <= '0;
                    r_emitted <= '0;
                    r_addr    <= '0;
                    r_pend    <= 1'b0;
                    if (in_acc) begin
                        if (!full) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_addr < r_count) begin
                        r_addr <= r_addr + CNT_W'(1);
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        r_used[best_idx] <= 1'b1;
                        r_emitted        <= r_emitted + CNT_W'(1);
                        r_addr           <= '0;
                        if (is_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && r_addr < r_count) begin
            r_pend_idx <= r_addr[IDX_W-1:0];
        end
    end

    a_no_empty_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (r_count != '0))
        else $error("result offered for an empty set");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_item.ready && o_res.valid))
        else $error("input ready while a result is pending");

    a_best_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> !r_used[best_idx])
        else $error("emitting an element already delivered");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_emitted < r_count))
        else $error("more results than stored elements");

    a_last_ends_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_res.last_res) |=> (r_state == ST_FILL && r_count == '0))
        else $error("set not closed after final result");
endmodule
